### src/itl_pkg.sv
// Shared types and constants for the impact threshold latch.
// Used by the controller, the datapath, the top level and the testbench.
package itl_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_TIMEOUT   = 2'd1;

    localparam logic [14:0] THRESHOLD_RESET = 15'd2000;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

    localparam int          CNT_W        = 4;
    localparam logic [CNT_W-1:0] SQUARE_LAST = CNT_W'(2);
    localparam logic [CNT_W-1:0] ROOT_LAST   = CNT_W'(14);
    localparam logic [29:0] ROOT_BIT_INIT    = 30'(1) << 28;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FORCE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       load;
        logic       square;
        logic [1:0] axis;
        logic       root_step;
        logic       gravity;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic in_sample;
    } t_status;

endpackage

### src/itl_ctrl.sv
// Sequencer for the impact threshold latch: steps each sample request
// through squaring, root extraction and latch update. Uses itl_pkg.
module itl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  itl_pkg::t_status  i_status,
    output itl_pkg::t_cmd     o_cmd
);

    itl_pkg::t_state              r_state, n_state;
    logic [itl_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itl_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.axis  = r_count[1:0];
        case (r_state)
            itl_pkg::ST_IDLE: begin
                n_count = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.in_sample ? itl_pkg::ST_SQUARE : itl_pkg::ST_FINISH;
                end
            end
            itl_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                if (r_count == itl_pkg::SQUARE_LAST) begin
                    n_count = '0;
                    n_state = itl_pkg::ST_ROOT;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            itl_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_count == itl_pkg::ROOT_LAST) begin
                    n_count = '0;
                    n_state = itl_pkg::ST_FORCE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            itl_pkg::ST_FORCE: begin
                o_cmd.gravity = 1'b1;
                n_state = itl_pkg::ST_FINISH;
            end
            itl_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = itl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == itl_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/itl_dp.sv
// Datapath for the impact threshold latch: configuration registers, shared
// squarer, bit-serial square root, crash latch and result register. Uses itl_pkg.
module itl_dp #(
    parameter int GRAVITY_MG = 1000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_opcode,
    input  logic [14:0]       i_accel_x,
    input  logic [14:0]       i_accel_y,
    input  logic [14:0]       i_accel_z,
    input  itl_pkg::t_cmd     i_cmd,
    output itl_pkg::t_status  o_status,
    output logic              o_crash_line,
    output logic              o_crashed,
    output logic              o_new_crash,
    output logic              o_high_impact,
    output logic [14:0]       o_sample_force,
    output logic [14:0]       o_latched_force
);

    localparam logic [14:0] GRAVITY = 15'(GRAVITY_MG);

    logic [14:0] r_threshold;
    logic [15:0] r_timeout;
    logic        r_latch, n_latch;
    logic [14:0] r_stored, n_stored;
    logic [15:0] r_left, n_left;

    logic [1:0]  r_op;
    logic [14:0] r_ax, r_ay, r_az;
    logic [29:0] r_rem;
    logic [29:0] r_root;
    logic [29:0] r_bit;
    logic [14:0] r_force;

    logic        r_crash_line, r_crashed, r_new_crash, r_high_impact;
    logic [14:0] r_sample_force, r_latched_force;

    logic [14:0] axis_val;
    logic [14:0] axis_mag;
    logic [29:0] square;
    logic [30:0] trial;
    logic        fresh;
    logic        high;

    assign o_status.in_sample = (i_opcode == itl_pkg::OP_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= itl_pkg::THRESHOLD_RESET;
            r_timeout   <= itl_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == itl_pkg::REG_THRESHOLD && i_cfg_data[14:0] != '0) begin
                r_threshold <= i_cfg_data[14:0];
            end
            if (i_cfg_index == itl_pkg::REG_TIMEOUT && i_cfg_data != '0) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_comb begin
        case (i_cmd.axis)
            2'd0:    axis_val = r_ax;
            2'd1:    axis_val = r_ay;
            default: axis_val = r_az;
        endcase
        axis_mag = axis_val[14] ? 15'(-axis_val) : axis_val;
        square   = 30'(axis_mag) * 30'(axis_mag);
        trial    = {1'b0, r_root} + {1'b0, r_bit};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_rem   <= '0;
            r_root  <= '0;
            r_bit   <= itl_pkg::ROOT_BIT_INIT;
            r_force <= '0;
        end
        if (i_cmd.square) begin
            r_rem <= r_rem + square;
        end
        if (i_cmd.root_step) begin
            if ({1'b0, r_rem} >= trial) begin
                r_rem  <= r_rem - trial[29:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.gravity) begin
            r_force <= (r_root[14:0] > GRAVITY) ? r_root[14:0] - GRAVITY : '0;
        end
    end

    always_comb begin
        n_latch  = r_latch;
        n_stored = r_stored;
        n_left   = r_left;
        fresh    = 1'b0;
        high     = 1'b0;
        case (r_op)
            itl_pkg::OP_SAMPLE: begin
                fresh = (r_force > r_threshold) && !r_latch;
                high  = {r_force, 1'b0} > {1'b0, r_threshold};
                if (fresh) begin
                    n_latch  = 1'b1;
                    n_stored = r_force;
                    n_left   = r_timeout;
                end
            end
            itl_pkg::OP_TICK: begin
                if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                    if (r_left == 16'd1) begin
                        n_latch  = 1'b0;
                        n_stored = '0;
                    end
                end
            end
            itl_pkg::OP_RESET: begin
                n_latch  = 1'b0;
                n_stored = '0;
                n_left   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= 1'b0;
            r_stored <= '0;
            r_left   <= '0;
        end else if (i_cmd.finish) begin
            r_latch  <= n_latch;
            r_stored <= n_stored;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_crash_line    <= !n_latch;
            r_crashed       <= n_latch;
            r_new_crash     <= fresh;
            r_high_impact   <= high;
            r_sample_force  <= r_force;
            r_latched_force <= n_latch ? n_stored : '0;
        end
    end

    assign o_crash_line    = r_crash_line;
    assign o_crashed       = r_crashed;
    assign o_new_crash     = r_new_crash;
    assign o_high_impact   = r_high_impact;
    assign o_sample_force  = r_sample_force;
    assign o_latched_force = r_latched_force;

endmodule

### src/impact_threshold_latch.sv
// Top level of the impact threshold latch: joins the controller and datapath.
// Depends on itl_pkg, itl_ctrl and itl_dp.
//
// Each request gives exactly one result. A sample request passes from acceptance
// through one load step, three steps on the shared 15x15 squarer, fifteen steps
// of the bit-serial square root, one step to remove gravity and a last step to
// update the latch and fill the output register; then it is ready again. Tick
// and manual reset requests go from the load step to the last step. A finished
// result waits in the output register while the next request is taken; the last
// step holds only while that register is still full. Configuration writes are
// always taken; a write of all-zero stored bits or to an unused index is dropped.
module impact_threshold_latch #(
    parameter int GRAVITY_MG = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [14:0] i_accel_x,
    input  logic [14:0] i_accel_y,
    input  logic [14:0] i_accel_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_crash_line,
    output logic        o_crashed,
    output logic        o_new_crash,
    output logic        o_high_impact,
    output logic [14:0] o_sample_force,
    output logic [14:0] o_latched_force
);

    itl_pkg::t_cmd    cmd;
    itl_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    itl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    itl_dp #(
        .GRAVITY_MG (GRAVITY_MG)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_crash_line    (o_crash_line),
        .o_crashed       (o_crashed),
        .o_new_crash     (o_new_crash),
        .o_high_impact   (o_high_impact),
        .o_sample_force  (o_sample_force),
        .o_latched_force (o_latched_force)
    );

endmodule

### src/itl_checker.sv
// Port-level checks for the impact threshold latch, bound to the top level.
// Depends on impact_threshold_latch port names only.
module itl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_crash_line,
    input logic        o_crashed,
    input logic        o_new_crash,
    input logic        o_high_impact,
    input logic [14:0] o_sample_force,
    input logic [14:0] o_latched_force
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_force)
            && $stable(o_latched_force) && $stable(o_crashed))
        else $error("result changed while stalled");

    a_line_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_crash_line == !o_crashed)
        else $error("crash line disagrees with latch");

    a_new_crash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_crash |-> o_crashed && o_high_impact
            && o_latched_force == o_sample_force)
        else $error("new crash without matching latch");

    a_idle_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_crashed |-> o_latched_force == 15'd0)
        else $error("latched force not cleared");

endmodule

bind impact_threshold_latch itl_checker u_itl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_crash_line    (o_crash_line),
    .o_crashed       (o_crashed),
    .o_new_crash     (o_new_crash),
    .o_high_impact   (o_high_impact),
    .o_sample_force  (o_sample_force),
    .o_latched_force (o_latched_force)
);

### verif/tb.sv
// Self-checking bench for impact_threshold_latch: a directed table, then randomised
// phases under varied backpressure; every result is compared field by field with a
// table row or an in-bench predictor. Depends on itl_pkg and the impact_threshold_latch RTL.
module tb;
    import itl_pkg::*;

    localparam int GRAVITY_MG = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 13;
    localparam int PHASE_REQUESTS = 100;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] ax;
        logic [14:0] ay;
        logic [14:0] az;
    } t_request;

    typedef struct packed {
        logic        crash_line;
        logic        crashed;
        logic        new_crash;
        logic        high_impact;
        logic [14:0] sample_force;
        logic [14:0] latched_force;
    } t_outcome;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  code;
        logic [14:0] ax;
        logic [14:0] ay;
        logic [14:0] az;
        logic [15:0] data;
        logic        typed;
        t_outcome    want;
    } t_row;

    localparam t_outcome QUIET = '{1'b1, 1'b0, 1'b0, 1'b0, 15'd0, 15'd0};
    localparam t_outcome NONE  = '0;
    localparam logic [14:0] AX_MIN = 15'h4000;
    localparam logic [14:0] AX_MAX = 15'h3FFF;
    localparam logic [14:0] ONES   = 15'h7FFF;
    localparam logic [14:0] Z15    = 15'd0;

    localparam int DIRECTED_ROWS = 29;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_ITEM, OP_SAMPLE, Z15, Z15, Z15, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, 15'd1000, Z15, Z15, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, 15'd3000, Z15, Z15, 16'd0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b1, 15'd2000, 15'd0}},
        '{ROW_ITEM, OP_TICK, Z15, Z15, Z15, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_UNUSED, ONES, ONES, ONES, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, 15'd3001, Z15, Z15, 16'd0, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b1, 15'd2001, 15'd2001}},
        '{ROW_ITEM, OP_SAMPLE, AX_MIN, AX_MIN, AX_MIN, 16'd0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b1, 15'd27377, 15'd2001}},
        '{ROW_ITEM, OP_TICK, Z15, Z15, Z15, 16'd0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 15'd0, 15'd2001}},
        '{ROW_ITEM, OP_UNUSED, Z15, Z15, Z15, 16'd0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b0, 15'd0, 15'd2001}},
        '{ROW_ITEM, OP_RESET, ONES, ONES, ONES, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, AX_MAX, AX_MAX, AX_MAX, 16'd0, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b1, 15'd27376, 15'd27376}},
        '{ROW_ITEM, OP_RESET, Z15, Z15, Z15, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, -15'sd3000, 15'd4000, Z15, 16'd0, 1'b0, NONE},
        '{ROW_CFG, REG_THRESHOLD, Z15, Z15, Z15, 16'd0, 1'b0, NONE},
        '{ROW_CFG, REG_TIMEOUT, Z15, Z15, Z15, 16'd0, 1'b0, NONE},
        '{ROW_CFG, REG_SPARE_A, Z15, Z15, Z15, 16'hFFFF, 1'b0, NONE},
        '{ROW_CFG, REG_SPARE_B, Z15, Z15, Z15, 16'hFFFF, 1'b0, NONE},
        '{ROW_CFG, REG_THRESHOLD, Z15, Z15, Z15, 16'h8000, 1'b0, NONE},
        '{ROW_CFG, REG_THRESHOLD, Z15, Z15, Z15, 16'd1, 1'b0, NONE},
        '{ROW_CFG, REG_TIMEOUT, Z15, Z15, Z15, 16'd1, 1'b0, NONE},
        '{ROW_ITEM, OP_RESET, Z15, Z15, Z15, 16'd0, 1'b1, QUIET},
        '{ROW_ITEM, OP_SAMPLE, Z15, Z15, 15'd1002, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, OP_SAMPLE, Z15, Z15, 15'd1001, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, OP_TICK, Z15, Z15, Z15, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, OP_TICK, Z15, Z15, Z15, 16'd0, 1'b0, NONE},
        '{ROW_CFG, REG_THRESHOLD, Z15, Z15, Z15, 16'hFFFF, 1'b0, NONE},
        '{ROW_CFG, REG_TIMEOUT, Z15, Z15, Z15, 16'hFFFF, 1'b0, NONE},
        '{ROW_ITEM, OP_SAMPLE, AX_MIN, AX_MIN, AX_MIN, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, OP_SAMPLE, Z15, Z15, Z15, 16'd0, 1'b0, NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = 2'd0;
    logic [14:0] i_accel_x = 15'd0;
    logic [14:0] i_accel_y = 15'd0;
    logic [14:0] i_accel_z = 15'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_crash_line;
    logic        o_crashed;
    logic        o_new_crash;
    logic        o_high_impact;
    logic [14:0] o_sample_force;
    logic [14:0] o_latched_force;

    logic [14:0] thr_mg;
    logic [15:0] timeout_cfg;
    logic        latch_set;
    logic [14:0] latched_mg;
    logic [15:0] ticks_left;

    t_outcome    pending_outcomes[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    impact_threshold_latch #(.GRAVITY_MG(GRAVITY_MG)) DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // hold ready low for a requested stretch, otherwise stall at the phase rate
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        got = '{o_crash_line, o_crashed, o_new_crash, o_high_impact,
                o_sample_force, o_latched_force};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $error("result with no request outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (got.crash_line !== want.crash_line) begin
                    mismatches++;
                    $error("crash_line: expected %0d, got %0d", want.crash_line, got.crash_line);
                end
                if (got.crashed !== want.crashed) begin
                    mismatches++;
                    $error("crashed: expected %0d, got %0d", want.crashed, got.crashed);
                end
                if (got.new_crash !== want.new_crash) begin
                    mismatches++;
                    $error("new_crash: expected %0d, got %0d", want.new_crash, got.new_crash);
                end
                if (got.high_impact !== want.high_impact) begin
                    mismatches++;
                    $error("high_impact: expected %0d, got %0d",
                           want.high_impact, got.high_impact);
                end
                if (got.sample_force !== want.sample_force) begin
                    mismatches++;
                    $error("sample_force: expected %0d, got %0d",
                           want.sample_force, got.sample_force);
                end
                if (got.latched_force !== want.latched_force) begin
                    mismatches++;
                    $error("latched_force: expected %0d, got %0d",
                           want.latched_force, got.latched_force);
                end
            end
        end
    end

    function automatic t_outcome impact_outcome(input t_request rq);
        t_outcome res;
        int sx;
        int sy;
        int sz;
        int sum;
        int root;
        int trial;
        int force_mg;
        res = '0;
        force_mg = 0;
        case (rq.op)
            OP_SAMPLE: begin
                sx = $signed(rq.ax);
                sy = $signed(rq.ay);
                sz = $signed(rq.az);
                sum = sx * sx + sy * sy + sz * sz;
                root = 0;
                for (int b = 14; b >= 0; b--) begin
                    trial = root | (1 << b);
                    if (trial * trial <= sum)
                        root = trial;
                end
                force_mg = (root > GRAVITY_MG) ? root - GRAVITY_MG : 0;
                if (force_mg > int'(thr_mg) && !latch_set) begin
                    latch_set = 1'b1;
                    latched_mg = force_mg[14:0];
                    ticks_left = timeout_cfg;
                    res.new_crash = 1'b1;
                end
                res.high_impact = (2 * force_mg > int'(thr_mg));
            end
            OP_TICK: begin
                if (ticks_left != 16'd0) begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0) begin
                        latch_set = 1'b0;
                        latched_mg = 15'd0;
                    end
                end
            end
            OP_RESET: begin
                latch_set = 1'b0;
                latched_mg = 15'd0;
                ticks_left = 16'd0;
            end
            default: ;
        endcase
        res.crash_line = !latch_set;
        res.crashed = latch_set;
        res.sample_force = force_mg[14:0];
        res.latched_force = latch_set ? latched_mg : 15'd0;
        return res;
    endfunction

    task automatic offer_request(input t_request rq, input logic typed, input t_outcome want);
        t_outcome predicted;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_opcode <= rq.op;
        i_accel_x <= rq.ax;
        i_accel_y <= rq.ay;
        i_accel_z <= rq.az;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = impact_outcome(rq);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_outcomes();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] data,
                                  input logic more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_THRESHOLD: if (data[14:0] != 15'd0) thr_mg = data[14:0];
            REG_TIMEOUT:   if (data != 16'd0) timeout_cfg = data;
            default: ;
        endcase
        if (!more)
            i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_request    rq;
        logic [14:0] axes [3];
        logic [14:0] thr_word;
        logic [15:0] tmo_word;
        logic [1:0]  junk_index;
        logic        junk;
        int          pick;
        int          target;
        int          v;

        thr_mg = THRESHOLD_RESET;
        timeout_cfg = TIMEOUT_RESET;
        latch_set = 1'b0;
        latched_mg = 15'd0;
        ticks_left = 16'd0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                if (r == 0 || DIRECTED[r - 1].kind != ROW_CFG)
                    wait_for_outcomes();
                write_register(DIRECTED[r].code, DIRECTED[r].data,
                               r + 1 < DIRECTED_ROWS && DIRECTED[r + 1].kind == ROW_CFG);
            end else begin
                rq = '{DIRECTED[r].code, DIRECTED[r].ax, DIRECTED[r].ay, DIRECTED[r].az};
                offer_request(rq, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_for_outcomes();
            case (p % 6)
                0: thr_word = 15'($urandom_range(4000, 300));
                1: thr_word = 15'd1;
                2: thr_word = 15'h7FFF;
                3: thr_word = 15'($urandom_range(32767, 1));
                4: thr_word = 15'd32000;
                default: thr_word = 15'($urandom_range(2500, 100));
            endcase
            case (p % 5)
                3: tmo_word = 16'hFFFF;
                4: tmo_word = 16'd1;
                default: tmo_word = 16'($urandom_range(12, 2));
            endcase
            junk = ($urandom_range(2) == 0);
            write_register(REG_THRESHOLD, {1'($urandom_range(1)), thr_word}, 1'b1);
            write_register(REG_TIMEOUT, tmo_word, junk);
            if (junk) begin
                junk_index = 2'($urandom_range(3));
                write_register(junk_index,
                               (junk_index == REG_THRESHOLD || junk_index == REG_TIMEOUT)
                               ? 16'd0 : 16'($urandom), 1'b0);
            end

            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (p == 4)
                hold_request = 400;

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                pick = $urandom_range(99);
                rq = '{OP_SAMPLE, 15'($urandom), 15'($urandom), 15'($urandom)};
                if (pick < 45) begin
                    for (int k = 0; k < 3; k++) begin
                        v = $urandom_range(60);
                        axes[k] = $urandom_range(1) ? 15'(-v) : 15'(v);
                    end
                    target = int'(thr_mg) + GRAVITY_MG + int'($urandom_range(80)) - 40;
                    if (target > 16383 || target < 0)
                        target = $urandom_range(16383);
                    axes[$urandom_range(2)] = $urandom_range(1) ? 15'(-target) : 15'(target);
                    rq.ax = axes[0];
                    rq.ay = axes[1];
                    rq.az = axes[2];
                end else if (pick < 60)
                    rq.op = OP_SAMPLE;
                else if (pick < 88)
                    rq.op = OP_TICK;
                else if (pick < 95)
                    rq.op = OP_RESET;
                else
                    rq.op = OP_UNUSED;
                offer_request(rq, 1'b0, NONE);
            end
        end

        wait_for_outcomes();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/itl_pkg.sv
src/itl_ctrl.sv
src/itl_dp.sv
src/impact_threshold_latch.sv
src/itl_checker.sv
verif/tb.sv
